>>> src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg: shared definitions for the byte queue with search
// Operation codes, payload field widths and default sizes.
// ----------------------------------------------------------------------------
package bfs_pkg;

  // Payload field widths
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int CNT_W  = 13;
  localparam int LEN_W  = 7;

  // Default sizes
  localparam int DEPTH_DEFAULT    = 4096;
  localparam int MAX_READ_DEFAULT = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

endpackage

>>> src/bfs_wrap_add.sv
// ----------------------------------------------------------------------------
// bfs_wrap_add: circular store address unit
// Adds an offset to the front index and wraps modulo DEPTH. Both operands
// stay below DEPTH, so one compare and subtract does the wrap.
// ----------------------------------------------------------------------------
module bfs_wrap_add #(
  parameter int DEPTH = 4096
) (
  input  logic [$clog2(DEPTH)-1:0]   base,
  input  logic [$clog2(DEPTH+1)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0]   slot
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  assign sum     = (CW+1)'(base) + (CW+1)'(offset);
  assign wrapped = (sum >= (CW+1)'(DEPTH)) ? (sum - (CW+1)'(DEPTH)) : sum;
  assign slot    = wrapped[IW-1:0];

endmodule

>>> src/byte_fifo_with_search.sv
// ----------------------------------------------------------------------------
// byte_fifo_with_search: byte queue with random read and search
// Circular byte store with push, pop, read, find and clear requests.
// ----------------------------------------------------------------------------
// Each request names one operation. Push, pop, clear and unused codes finish
// in the cycle they are accepted and give one result; a new request can be
// taken every cycle as long as the result register is drained. Read walks
// the store a byte at a time (an address state, then registered data) and
// gives one result per byte, the final one marked by last; a read starting
// at or past the occupancy gives a single error result, and a zero length
// read within range gives none. Find scans from the front one byte per cycle
// through the store's single read port and stops at the first match. All
// address arithmetic goes through one shared wrap-around adder. The store
// has no reset; only pushed bytes are read. in_stall is high while a read or
// find is in progress or while a result is waiting and stalled.
// ----------------------------------------------------------------------------
module byte_fifo_with_search
  import bfs_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEFAULT,
  parameter int MAX_READ = MAX_READ_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [POS_W-1:0]  position,
  input  logic [CNT_W-1:0]  amount,
  input  logic [LEN_W-1:0]  read_length,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] byte_out,
  output logic              found,
  output logic [CNT_W-1:0]  position_out,
  output logic [CNT_W-1:0]  occupancy,
  output logic              error,
  output logic              last
);

  localparam int IW = $clog2(DEPTH);        // store index
  localparam int CW = $clog2(DEPTH + 1);    // count / offset, holds DEPTH
  localparam int AW = (CW > CNT_W) ? CW : CNT_W;  // compare width
  localparam int LW = $clog2(MAX_READ + 1); // read run counter

  // Sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_FIND    = 2'd1;
  localparam logic [1:0] S_RD_ADDR = 2'd2;
  localparam logic [1:0] S_RD_DATA = 2'd3;

  // Byte store, no reset
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;

  // Control state
  logic [1:0]    state, state_next;
  logic [CW-1:0] held_count, held_count_next;
  logic [IW-1:0] front_index, front_index_next;
  logic [CW-1:0] walk_off, walk_off_next;   // offset being read
  logic [CW-1:0] cmp_off, cmp_off_next;     // offset of byte in rd_data
  logic          cmp_valid, cmp_valid_next;
  logic [LW-1:0] rd_left, rd_left_next;     // bytes still to emit
  logic [BYTE_W-1:0] key, key_next;

  // Result register
  logic              out_valid_next;
  logic [BYTE_W-1:0] byte_out_next;
  logic              found_next;
  logic [CNT_W-1:0]  position_out_next;
  logic [CNT_W-1:0]  occupancy_next;
  logic              error_next;
  logic              last_next;

  // Store ports and shared adder
  logic              rd_en;
  logic              wr_en;
  logic [CW-1:0]     add_off;
  logic [IW-1:0]     slot;

  logic              out_free;
  logic              accept;
  logic              issue_ok;
  logic [LEN_W-1:0]  req_len;
  logic [AW-1:0]     avail;
  logic [LW-1:0]     run_len;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign issue_ok = walk_off < held_count;

  // Offset select for the shared adder: tail for push, amount for pop,
  // walking offset for read and find.
  always_comb begin
    if (state == S_IDLE) begin
      add_off = (operation == OP_PUSH) ? held_count : CW'(amount);
    end else begin
      add_off = walk_off;
    end
  end

  bfs_wrap_add #(
    .DEPTH (DEPTH)
  ) u_wrap_add (
    .base   (front_index),
    .offset (add_off),
    .slot   (slot)
  );

  // Read run length: saturate at MAX_READ, clip to bytes past position
  assign req_len = (read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : read_length;
  assign avail   = AW'(held_count) - AW'(position);
  assign run_len = (AW'(req_len) > avail) ? LW'(avail) : LW'(req_len);

  always_comb begin
    state_next        = state;
    held_count_next   = held_count;
    front_index_next  = front_index;
    walk_off_next     = walk_off;
    cmp_off_next      = cmp_off;
    cmp_valid_next    = 1'b0;
    rd_left_next      = rd_left;
    key_next          = key;
    rd_en             = 1'b0;
    wr_en             = 1'b0;

    out_valid_next    = out_valid && out_stall;
    byte_out_next     = byte_out;
    found_next        = found;
    position_out_next = position_out;
    occupancy_next    = occupancy;
    error_next        = error;
    last_next         = last;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // Most requests give one plain result; fields filled below
          byte_out_next     = '0;
          found_next        = 1'b0;
          position_out_next = '0;
          error_next        = 1'b0;
          last_next         = 1'b1;
          out_valid_next    = 1'b1;
          case (operation)
            OP_PUSH: begin
              if (held_count < CW'(DEPTH)) begin
                wr_en           = 1'b1;
                held_count_next = held_count + CW'(1);
              end else begin
                error_next = 1'b1;
              end
            end
            OP_POP: begin
              if (AW'(amount) >= AW'(held_count)) begin
                held_count_next  = '0;
                front_index_next = '0;
              end else begin
                front_index_next = slot;
                held_count_next  = held_count - CW'(amount);
              end
            end
            OP_READ: begin
              if (AW'(position) >= AW'(held_count)) begin
                error_next = 1'b1;
              end else begin
                out_valid_next = out_valid && out_stall;
                if (run_len != '0) begin
                  walk_off_next = CW'(position);
                  rd_left_next  = run_len;
                  state_next    = S_RD_ADDR;
                end
              end
            end
            OP_FIND: begin
              out_valid_next = out_valid && out_stall;
              key_next       = data_byte;
              walk_off_next  = '0;
              state_next     = S_FIND;
            end
            OP_CLEAR: begin
              held_count_next  = '0;
              front_index_next = '0;
            end
            default: begin
              // unused code: occupancy only
            end
          endcase
          occupancy_next = CNT_W'(held_count_next);
        end
      end

      S_FIND: begin
        // One read issued per cycle while bytes remain, compared in the next cycle
        rd_en          = issue_ok;
        cmp_valid_next = issue_ok;
        cmp_off_next   = walk_off;
        if (issue_ok) begin
          walk_off_next = walk_off + CW'(1);
        end
        if (cmp_valid && (rd_data == key)) begin
          out_valid_next    = 1'b1;
          byte_out_next     = '0;
          found_next        = 1'b1;
          position_out_next = CNT_W'(cmp_off);
          occupancy_next    = CNT_W'(held_count);
          error_next        = 1'b0;
          last_next         = 1'b1;
          state_next        = S_IDLE;
        end else if (!cmp_valid && !issue_ok) begin
          out_valid_next    = 1'b1;
          byte_out_next     = '0;
          found_next        = 1'b0;
          position_out_next = CNT_W'(held_count);
          occupancy_next    = CNT_W'(held_count);
          error_next        = 1'b0;
          last_next         = 1'b1;
          state_next        = S_IDLE;
        end
      end

      S_RD_ADDR: begin
        rd_en      = 1'b1;
        state_next = S_RD_DATA;
      end

      S_RD_DATA: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          byte_out_next     = rd_data;
          found_next        = 1'b0;
          position_out_next = CNT_W'(walk_off);
          occupancy_next    = CNT_W'(held_count);
          error_next        = 1'b0;
          last_next         = (rd_left == LW'(1));
          walk_off_next     = walk_off + CW'(1);
          rd_left_next      = rd_left - LW'(1);
          state_next        = (rd_left == LW'(1)) ? S_IDLE : S_RD_ADDR;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= data_byte;
    end
    if (rd_en) begin
      rd_data <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held_count  <= '0;
      front_index <= '0;
      cmp_valid   <= 1'b0;
      rd_left     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      held_count  <= held_count_next;
      front_index <= front_index_next;
      cmp_valid   <= cmp_valid_next;
      rd_left     <= rd_left_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    walk_off     <= walk_off_next;
    cmp_off      <= cmp_off_next;
    key          <= key_next;
    byte_out     <= byte_out_next;
    found        <= found_next;
    position_out <= position_out_next;
    occupancy    <= occupancy_next;
    error        <= error_next;
    last         <= last_next;
  end

  // Assertions

  // Result register must be empty for the whole scan
  a_find_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> !out_valid)
    else $error("result pending during find scan");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DEPTH))
    else $error("held count exceeds store depth");

  a_read_run: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RD_ADDR) || (state == S_RD_DATA)) |-> (rd_left != '0))
    else $error("read run active with nothing left");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_PUSH) && (held_count < CW'(DEPTH)))
      |=> (held_count == $past(held_count) + CW'(1)))
    else $error("push did not advance held count");

endmodule

>>> dv/tb_byte_fifo_with_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_fifo_with_search: self-checking bench for the byte queue with search
// Sends push, pop, read, find and clear requests with random idling on both
// channels. A scoreboard predicts every result and checks each one in order.
// ----------------------------------------------------------------------------
module tb_byte_fifo_with_search;
  import bfs_pkg::*;

  localparam int QDEPTH          = DEPTH_DEFAULT;
  localparam int RUN_MAX         = MAX_READ_DEFAULT;
  localparam int LEN_TOP         = (1 << LEN_W) - 1;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int RANDOM_REQUESTS = 390;
  localparam int QUIET_TAIL      = 60;

  // Codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [BYTE_W-1:0] byte_val;
    logic              hit;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  occ;
    logic              err;
    logic              tail;
  } queue_result_t;

  // Shadow copy of the queue; predicts results and checks them in order.
  class byte_queue_scoreboard;
    logic [BYTE_W-1:0] byte_mem [QDEPTH];
    logic [POS_W-1:0]  front_idx;
    logic [CNT_W-1:0]  held;
    queue_result_t     pending_results [$];
    int                mismatch_count;

    function new();
      front_idx      = '0;
      held           = '0;
      mismatch_count = 0;
    endfunction

    // store index of an offset from the front; wraps since depth is 2**POS_W
    function logic [POS_W-1:0] slot(int offset);
      return front_idx + POS_W'(offset);
    endfunction

    function logic [BYTE_W-1:0] byte_at(int offset);
      return byte_mem[slot(offset)];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void add_result(logic [BYTE_W-1:0] b, logic f, int p, logic e, logic l);
      queue_result_t r;
      r.byte_val = b;
      r.hit      = f;
      r.pos      = CNT_W'(p);
      r.occ      = held;
      r.err      = e;
      r.tail     = l;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                               logic [POS_W-1:0] pos, logic [CNT_W-1:0] amt,
                               logic [LEN_W-1:0] len);
      int run;
      case (op)
        OP_PUSH: begin
          if (held >= QDEPTH) begin
            add_result('0, 1'b0, 0, 1'b1, 1'b1);    // full: byte dropped
          end else begin
            byte_mem[slot(int'(held))] = data;
            held++;
            add_result('0, 1'b0, 0, 1'b0, 1'b1);
          end
        end
        OP_POP: begin
          if (amt >= held) begin
            held      = '0;
            front_idx = '0;
          end else begin
            front_idx = slot(int'(amt));
            held      = held - amt;
          end
          add_result('0, 1'b0, 0, 1'b0, 1'b1);
        end
        OP_READ: begin
          if (pos >= held) begin
            add_result('0, 1'b0, 0, 1'b1, 1'b1);
          end else begin
            run = (len > RUN_MAX) ? RUN_MAX : int'(len);
            if (run > int'(held) - int'(pos)) run = int'(held) - int'(pos);
            // zero length in range gives nothing at all
            for (int i = 0; i < run; i++)
              add_result(byte_mem[slot(int'(pos) + i)], 1'b0, int'(pos) + i, 1'b0,
                         i == run - 1);
          end
        end
        OP_FIND: begin
          for (int i = 0; i < held; i++) begin
            if (byte_mem[slot(i)] == data) begin
              add_result('0, 1'b1, i, 1'b0, 1'b1);
              return;
            end
          end
          add_result('0, 1'b0, int'(held), 1'b0, 1'b1);
        end
        OP_CLEAR: begin
          held      = '0;
          front_idx = '0;
          add_result('0, 1'b0, 0, 1'b0, 1'b1);
        end
        default: begin
          add_result('0, 1'b0, 0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: byte_out %0d position_out %0d occupancy %0d",
               got.byte_val, got.pos, got.occ);
        mismatch_count++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      compare_field("byte_out", CNT_W'(want.byte_val), CNT_W'(got.byte_val));
      compare_field("found", CNT_W'(want.hit), CNT_W'(got.hit));
      compare_field("position_out", want.pos, got.pos);
      compare_field("occupancy", want.occ, got.occ);
      compare_field("error", CNT_W'(want.err), CNT_W'(got.err));
      compare_field("last", CNT_W'(want.tail), CNT_W'(got.tail));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  position;
  logic [CNT_W-1:0]  amount;
  logic [LEN_W-1:0]  read_length;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] byte_out;
  logic              found;
  logic [CNT_W-1:0]  position_out;
  logic [CNT_W-1:0]  occupancy;
  logic              error;
  logic              last;

  logic                 quiet;        // no idling on either side
  int                   out_burst = 0;
  int                   cycle_count;
  byte_queue_scoreboard sb;

  byte_fifo_with_search dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stall bursts, none once quiet.
  always @(posedge clk) begin
    if (quiet) out_burst = 0;
    else if (out_burst > 0) out_burst--;
    else if ($urandom_range(0, 5) == 0) out_burst = $urandom_range(1, 7);
    out_stall <= (out_burst != 0);
  end

  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(queue_result_t'{byte_out, found, position_out, occupancy, error, last});
  end

  // Holds one request until taken, notes it, then maybe idles for a burst.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                              input logic [POS_W-1:0] pos, input logic [CNT_W-1:0] amt,
                              input logic [LEN_W-1:0] len);
    operation   <= op;
    data_byte   <= data;
    position    <= pos;
    amount      <= amt;
    read_length <= len;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, data, pos, amt, len);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mix weighted toward a modest occupancy so finds stay short.
  task automatic random_request();
    int unsigned       pick;
    int                occ;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  amt;
    logic [LEN_W-1:0]  len;
    pick = $urandom_range(0, 99);
    occ  = int'(sb.held);
    // fields an operation ignores still carry noise
    data = BYTE_W'($urandom_range(0, 255));
    pos  = POS_W'($urandom_range(0, QDEPTH - 1));
    amt  = CNT_W'($urandom_range(0, QDEPTH));
    len  = LEN_W'($urandom_range(0, RUN_MAX));
    if (pick < ((occ < 150) ? 45 : 20)) begin
      op = OP_PUSH;
    end else if (pick < 55) begin
      op  = OP_POP;
      if ($urandom_range(0, 7) != 0) amt = CNT_W'($urandom_range(0, occ / 3 + 1));
    end else if (pick < 77) begin
      op = OP_READ;
      if (occ > 0 && $urandom_range(0, 7) != 0) pos = POS_W'($urandom_range(0, occ - 1));
      if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom_range(RUN_MAX + 1, LEN_TOP));
    end else if (pick < 94) begin
      op = OP_FIND;
      if (occ > 0 && $urandom_range(0, 3) != 0) data = sb.byte_at($urandom_range(0, occ - 1));
    end else if (pick < 97) begin
      op = OP_CLEAR;
    end else begin
      op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    send_request(op, data, pos, amt, len);
  endtask

  // Timeout watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $error("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, sb.pending());
    $display("byte_fifo_with_search: mismatch");
    $finish;
  end

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_PUSH;
    data_byte   = '0;
    position    = '0;
    amount      = '0;
    read_length = '0;
    quiet       = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: empty queue, field extremes, clipping, no-op codes ---
    send_request(OP_FIND, 8'h00, '0, '0, '0);             // empty: no match at 0
    send_request(OP_READ, 8'h00, '0, '0, 7'd1);           // empty: error
    send_request(OP_POP, 8'h00, '0, '0, '0);
    send_request(OP_PUSH, 8'h00, '0, '0, '0);
    send_request(OP_PUSH, 8'hFF, 12'hFFF, 13'd4096, 7'd127); // push ignores the rest
    send_request(OP_PUSH, 8'hA5, '0, '0, '0);
    send_request(OP_READ, 8'h00, '0, '0, '0);             // zero length: no result
    send_request(OP_READ, 8'h00, '0, '0, 7'd127);         // saturates, then clips to 3
    send_request(OP_READ, 8'h00, 12'd2, '0, 7'd64);       // clipped to last byte
    send_request(OP_READ, 8'h00, 12'd3, '0, 7'd1);        // at occupancy: error
    send_request(OP_READ, 8'h00, 12'hFFF, '0, 7'd64);     // far past the end
    send_request(OP_FIND, 8'hFF, '0, '0, '0);
    send_request(OP_FIND, 8'h42, '0, '0, '0);             // miss reports occupancy
    send_request(OP_POP, 8'h00, '0, 13'd1, '0);
    send_request(OP_SPARE_LO, 8'hFF, 12'hFFF, 13'd4096, 7'd127);
    send_request(OP_SPARE_LO + 3'd1, 8'h00, '0, '0, '0);
    send_request(OP_SPARE_HI, 8'h5A, 12'h800, 13'd2048, 7'd64);
    send_request(OP_POP, 8'h00, '0, 13'd4096, '0);        // empties, front back to 0
    send_request(OP_PUSH, 8'h5A, '0, '0, '0);
    send_request(OP_CLEAR, 8'h00, '0, '0, '0);
    send_request(OP_FIND, 8'h5A, '0, '0, '0);
    wait_for_results();

    // --- random traffic; the tail runs without idling ---
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet <= 1'b1;
      random_request();
    end

    wait_for_results();
    repeat (50) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("byte_fifo_with_search: match");
    else
      $display("byte_fifo_with_search: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
src/bfs_pkg.sv
src/bfs_wrap_add.sv
src/byte_fifo_with_search.sv
dv/tb_byte_fifo_with_search.sv
